// ----- design/utf8w_pkg.sv -----
// Package for the UTF-8 window decoder: constants, lane and result types,
// and the lead mask function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8w_pkg;

  localparam int unsigned LANES     = 6;   // octets after the lead
  localparam int unsigned CP_W      = 31;
  localparam int unsigned ADV_W     = 4;
  localparam int unsigned SEXTET_W  = 6;

  localparam logic [CP_W-1:0]  REPLACEMENT_CP = 31'h0000FFFD;
  localparam logic [7:0]       CONT_SEL_MASK  = 8'hC0;
  localparam logic [7:0]       CONT_PATTERN   = 8'h80;
  localparam logic [7:0]       SEXTET_MASK    = 8'h3F;

  // Leading-ones counts with special meaning
  localparam logic [ADV_W-1:0] ONES_ASCII = 4'd0;
  localparam logic [ADV_W-1:0] ONES_STRAY = 4'd1;
  localparam logic [ADV_W-1:0] ONES_MAX   = 4'd6;
  localparam logic [ADV_W-1:0] ADV_ASCII  = 4'd1;
  localparam logic [ADV_W-1:0] ADV_STRAY  = 4'd0;

  typedef struct packed {
    logic                is_cont;
    logic [SEXTET_W-1:0] sextet;
  } lane_t;

  typedef struct packed {
    logic [CP_W-1:0]  code_point;
    logic [ADV_W-1:0] advance;
    logic             decode_error;
  } result_t;

  // Payload bits kept from a lead with the given count of leading ones
  function automatic logic [7:0] lead_keep_mask(input logic [ADV_W-1:0] ones);
    logic [7:0] m;
    case (ones)
      4'd2:    m = 8'd31;
      4'd3:    m = 8'd15;
      4'd4:    m = 8'd7;
      4'd5:    m = 8'd3;
      4'd6:    m = 8'd1;
      default: m = 8'd0;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- design/utf8w_lane.sv -----
// One lane: classifies a non-lead octet and extracts its six payload bits.
// Depends on utf8w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8w_lane
  import utf8w_pkg::*;
(
  input  logic [7:0] octet_i,
  output lane_t      lane_o
);

  always_comb begin
    lane_o.is_cont = ((octet_i & CONT_SEL_MASK) == CONT_PATTERN);
    lane_o.sextet  = octet_i[SEXTET_W-1:0] & SEXTET_MASK[SEXTET_W-1:0];
  end

endmodule

`default_nettype wire

// ----- design/utf8w_merge.sv -----
// Merge stage: counts the lead's leading ones and combines the lane
// results into code point, advance and error flag. Depends on utf8w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8w_merge
  import utf8w_pkg::*;
(
  input  logic [7:0] lead_octet_i,
  input  lane_t      lanes_i [LANES],
  output result_t    result_o
);

  logic [ADV_W-1:0] ones;
  logic [CP_W-1:0]  cp;
  logic             bad;

  always_comb begin
    case (lead_octet_i) inside
      8'b0???????: ones = 4'd0;
      8'b10??????: ones = 4'd1;
      8'b110?????: ones = 4'd2;
      8'b1110????: ones = 4'd3;
      8'b11110???: ones = 4'd4;
      8'b111110??: ones = 4'd5;
      8'b1111110?: ones = 4'd6;
      8'b11111110: ones = 4'd7;
      default:     ones = 4'd8;
    endcase
  end

  always_comb begin
    cp  = {{(CP_W-8){1'b0}}, lead_octet_i & lead_keep_mask(ones)};
    bad = 1'b0;
    for (int i = 1; i <= LANES; i++) begin
      if (4'(i) < ones) begin
        cp = {cp[CP_W-SEXTET_W-1:0], lanes_i[i-1].sextet};
        if (!lanes_i[i-1].is_cont) bad = 1'b1;
      end
      // the octet right after the sequence must not be a continuation
      if (4'(i) == ones && lanes_i[i-1].is_cont) bad = 1'b1;
    end
  end

  always_comb begin
    if (ones == ONES_ASCII) begin
      result_o.code_point   = {{(CP_W-8){1'b0}}, lead_octet_i};
      result_o.advance      = ADV_ASCII;
      result_o.decode_error = 1'b0;
    end else if (ones == ONES_STRAY) begin
      result_o.code_point   = REPLACEMENT_CP;
      result_o.advance      = ADV_STRAY;
      result_o.decode_error = 1'b1;
    end else if (ones > ONES_MAX) begin
      result_o.code_point   = REPLACEMENT_CP;
      result_o.advance      = ones;
      result_o.decode_error = 1'b1;
    end else begin
      result_o.code_point   = bad ? REPLACEMENT_CP : cp;
      result_o.advance      = ones;
      result_o.decode_error = bad;
    end
  end

endmodule

`default_nettype wire

// ----- design/utf8w_unit.sv -----
// Output stage: result register plus a skid entry so a new request is
// taken while a result waits. Depends on utf8w_pkg.
`timescale 1ns / 1ps
`default_nettype none

module utf8w_unit
  import utf8w_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  result_t result_i,
  input  logic    out_stall_i,
  output logic    skid_full_o,
  output logic    out_valid_o,
  output result_t result_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_load;

  assign out_load = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_load) begin
      out_valid_d  = skid_valid_q || in_fire_i;
      out_d        = skid_valid_q ? skid_q : result_i;
      skid_valid_d = 1'b0;
    end else if (in_fire_i) begin
      skid_valid_d = 1'b1;
      skid_d       = result_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign skid_full_o = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q) else $error("skid entry held with empty output");

  a_skid_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q && !out_stall_i |=> !skid_valid_q) else $error("skid entry not drained");

  a_no_accept_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !in_fire_i) else $error("request taken with skid full");

endmodule

`default_nettype wire

// ----- design/utf8_window_decoder_unit.sv -----
// Top level of the UTF-8 window decoder: six octet lanes, merge stage and
// output stage. Depends on utf8w_pkg, utf8w_lane, utf8w_merge, utf8w_unit.
`timescale 1ns / 1ps
`default_nettype none

// Decodes one UTF-8 sequence per request from a seven-octet window that
// starts at a lead octet. A request is taken every cycle while in_stall_o
// is low; its result is held in the output register, or in the skid entry
// while the output stalls. Decoding is a single combinational pass (six
// lanes checking the following octets, one merge) ahead of that register,
// so throughput is one window per cycle while in_stall_o is low. A two-entry
// output stage (register plus skid) keeps taking requests while a result
// waits; in_stall_o rises only when both entries are full. Errors yield
// 0xFFFD with decode_error_o set; a stray continuation lead reports advance 0.
module utf8_window_decoder_unit
  import utf8w_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        lead_octet_i,
  input  logic [7:0]        octet_one_i,
  input  logic [7:0]        octet_two_i,
  input  logic [7:0]        octet_three_i,
  input  logic [7:0]        octet_four_i,
  input  logic [7:0]        octet_five_i,
  input  logic [7:0]        octet_six_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [CP_W-1:0]   code_point_o,
  output logic [ADV_W-1:0]  advance_o,
  output logic              decode_error_o
);

  logic [7:0] octets [LANES];
  lane_t      lanes  [LANES];
  result_t    result;
  result_t    out_result;
  logic       skid_full;
  logic       in_fire;

  assign octets[0] = octet_one_i;
  assign octets[1] = octet_two_i;
  assign octets[2] = octet_three_i;
  assign octets[3] = octet_four_i;
  assign octets[4] = octet_five_i;
  assign octets[5] = octet_six_i;

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    utf8w_lane u_lane (
      .octet_i (octets[g]),
      .lane_o  (lanes[g])
    );
  end

  utf8w_merge u_merge (
    .lead_octet_i (lead_octet_i),
    .lanes_i      (lanes),
    .result_o     (result)
  );

  assign in_stall_o = skid_full;
  assign in_fire    = in_valid_i && !skid_full;

  utf8w_unit u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .result_i    (result),
    .out_stall_i (out_stall_i),
    .skid_full_o (skid_full),
    .out_valid_o (out_valid_o),
    .result_o    (out_result)
  );

  assign code_point_o   = out_result.code_point;
  assign advance_o      = out_result.advance;
  assign decode_error_o = out_result.decode_error;

  a_error_gives_repl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && decode_error_o |-> code_point_o == REPLACEMENT_CP)
    else $error("error result without replacement code point");

  a_stray_is_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && advance_o == ADV_STRAY |-> decode_error_o)
    else $error("zero advance without error");

  a_good_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !decode_error_o |-> advance_o >= ADV_ASCII && advance_o <= ONES_MAX)
    else $error("clean result with bad advance");

endmodule

`default_nettype wire
